>>> hw/rtl/prq_pkg.sv
package prq_pkg;

  // Sizes of the queue and of the task id space.
  localparam int QUEUE_DEPTH   = 32;
  localparam int TASK_COUNT    = 64;
  localparam int PRIORITY_BITS = 8;

  // Field widths fixed by the interface.
  localparam int TASK_ID_W = 6;
  localparam int PRIO_W    = 8;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;

  // Derived widths of the queue bookkeeping.
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Only the low PRIORITY_BITS bits of a priority take part.
  localparam logic [PRIO_W-1:0] PRIO_MASK = PRIO_W'((1 << PRIORITY_BITS) - 1);

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_PICK    = 2'd1,
    CMD_STEAL   = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // One queue slot.
  typedef struct packed {
    logic [TASK_ID_W-1:0] id;
    logic [PRIO_W-1:0]    prio;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the incoming item
    logic commit;  // execute the held item and load the result register
  } ctrl_cmd_t;

endpackage

>>> hw/rtl/prq_ctrl.sv
module prq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output prq_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  // The result register is free when empty or when its transfer happens now.
  assign slot_free = !out_valid_q || out_ready_i;

  assign in_ready_o    = (state_q == S_IDLE);
  assign cmd_o.load    = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.commit  = (state_q == S_EXEC) && slot_free;
  assign out_valid_o   = out_valid_q;

  // Next state: S_IDLE captures an item, S_EXEC executes it once the result register is free.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> hw/rtl/prq_dp.sv
module prq_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  prq_pkg::ctrl_cmd_t                cmd_i,
  input  logic [prq_pkg::CMD_W-1:0]         in_command_i,
  input  logic [prq_pkg::TASK_ID_W-1:0]     in_task_id_i,
  input  logic [prq_pkg::PRIO_W-1:0]        in_task_priority_i,
  input  logic                              in_was_runnable_i,
  input  logic                              cfg_we_i,
  input  logic                              cfg_data_i,
  output logic [prq_pkg::STATUS_W-1:0]      status_o,
  output logic [prq_pkg::TASK_ID_W-1:0]     out_task_id_o,
  output logic [prq_pkg::PRIO_W-1:0]        out_task_priority_o,
  output logic                              preempt_request_o
);

  localparam int D = prq_pkg::QUEUE_DEPTH;

  // Held item.
  prq_pkg::cmd_e                    cmd_q;
  logic [prq_pkg::TASK_ID_W-1:0]    id_q;
  logic [prq_pkg::PRIO_W-1:0]       prio_q;
  logic                             run_q;

  // Scheduler state.
  prq_pkg::entry_t                  ent_q [D];
  prq_pkg::entry_t                  ent_d [D];
  logic [prq_pkg::CNT_W-1:0]        count_q, count_d;
  logic [prq_pkg::TASK_COUNT-1:0]   queued_q, queued_d;
  logic [prq_pkg::TASK_COUNT-1:0]   front_q, front_d;
  logic [prq_pkg::TASK_ID_W-1:0]    cur_id_q, cur_id_d;
  logic [prq_pkg::PRIO_W-1:0]       cur_prio_q, cur_prio_d;
  logic                             pe_q;

  // Result register.
  prq_pkg::status_e                 res_status_q, res_status_d;
  logic [prq_pkg::TASK_ID_W-1:0]    res_id_q, res_id_d;
  logic [prq_pkg::PRIO_W-1:0]       res_prio_q, res_prio_d;
  logic                             res_pre_q, res_pre_d;

  // Per-slot insert and pop views.
  logic                             keep [D];
  prq_pkg::entry_t                  ins_ent [D];
  prq_pkg::entry_t                  shl_ent [D];
  prq_pkg::entry_t                  new_ent;
  prq_pkg::entry_t                  pop_ent;
  logic [prq_pkg::IDX_W-1:0]        tail_idx;
  logic                             ins_front;
  logic                             id_ok;
  logic                             enq_ignore;
  logic                             q_full;
  logic                             q_empty;
  logic                             preempt;

  assign new_ent.id   = id_q;
  assign new_ent.prio = prio_q;
  assign id_ok        = (32'(id_q) < prq_pkg::TASK_COUNT);
  assign enq_ignore   = (id_q == '0) || !id_ok || queued_q[id_q];
  assign q_full       = (count_q == prq_pkg::CNT_W'(D));
  assign q_empty      = (count_q == '0);
  assign ins_front    = front_q[id_q];
  assign tail_idx     = prq_pkg::IDX_W'(count_q - prq_pkg::CNT_W'(1));
  assign preempt      = !run_q && pe_q && (cur_id_q != '0) && (prio_q < cur_prio_q);

  // Each slot decides for itself whether it stays, takes the new task or
  // takes its upper neighbor; the queue is sorted, so the kept slots are a
  // prefix.
  always_comb begin
    for (int i = 0; i < D; i++) begin
      keep[i] = (prq_pkg::CNT_W'(i) < count_q) &&
                (ins_front ? (ent_q[i].prio < prio_q) : (ent_q[i].prio <= prio_q));
    end
    for (int i = 0; i < D; i++) begin
      if (keep[i]) begin
        ins_ent[i] = ent_q[i];
      end else if (i == 0) begin
        ins_ent[i] = new_ent;
      end else if (keep[i-1]) begin
        ins_ent[i] = new_ent;
      end else begin
        ins_ent[i] = ent_q[i-1];
      end
      shl_ent[i] = (i < D - 1) ? ent_q[i+1] : ent_q[i];
    end
  end

  // Command execution.
  always_comb begin
    ent_d        = ent_q;
    count_d      = count_q;
    queued_d     = queued_q;
    front_d      = front_q;
    cur_id_d     = cur_id_q;
    cur_prio_d   = cur_prio_q;
    res_status_d = prq_pkg::ST_IGNORED;
    res_id_d     = '0;
    res_prio_d   = '0;
    res_pre_d    = 1'b0;
    pop_ent      = (cmd_q == prq_pkg::CMD_PICK) ? ent_q[0] : ent_q[tail_idx];
    unique case (cmd_q)
      prq_pkg::CMD_ENQUEUE: begin
        if (enq_ignore) begin
          res_status_d = prq_pkg::ST_IGNORED;
        end else if (q_full) begin
          res_status_d = prq_pkg::ST_FULL;
        end else begin
          ent_d          = ins_ent;
          count_d        = count_q + prq_pkg::CNT_W'(1);
          queued_d[id_q] = 1'b1;
          front_d[id_q]  = 1'b0;
          if (preempt) begin
            res_pre_d         = 1'b1;
            front_d[cur_id_q] = 1'b1;
          end
          res_status_d = prq_pkg::ST_DONE;
        end
      end
      prq_pkg::CMD_PICK, prq_pkg::CMD_STEAL: begin
        if (q_empty) begin
          res_status_d = prq_pkg::ST_EMPTY;
        end else begin
          if (cmd_q == prq_pkg::CMD_PICK) begin
            ent_d      = shl_ent;
            cur_id_d   = pop_ent.id;
            cur_prio_d = pop_ent.prio;
          end
          count_d             = count_q - prq_pkg::CNT_W'(1);
          queued_d[pop_ent.id] = 1'b0;
          res_status_d        = prq_pkg::ST_DONE;
          res_id_d            = pop_ent.id;
          res_prio_d          = pop_ent.prio;
        end
      end
      default: res_status_d = prq_pkg::ST_IGNORED;
    endcase
  end

  // Control state and bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      queued_q   <= '0;
      front_q    <= '0;
      cur_id_q   <= '0;
      cur_prio_q <= '0;
      pe_q       <= 1'b1;
    end else begin
      if (cmd_i.commit) begin
        count_q    <= count_d;
        queued_q   <= queued_d;
        front_q    <= front_d;
        cur_id_q   <= cur_id_d;
        cur_prio_q <= cur_prio_d;
      end
      if (cfg_we_i) begin
        pe_q <= cfg_data_i;
      end
    end
  end

  // Payload registers: held item, queue slots and result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= prq_pkg::cmd_e'(in_command_i);
      id_q   <= in_task_id_i;
      prio_q <= in_task_priority_i & prq_pkg::PRIO_MASK;
      run_q  <= in_was_runnable_i;
    end
    if (cmd_i.commit) begin
      ent_q        <= ent_d;
      res_status_q <= res_status_d;
      res_id_q     <= res_id_d;
      res_prio_q   <= res_prio_d;
      res_pre_q    <= res_pre_d;
    end
  end

  assign status_o            = res_status_q;
  assign out_task_id_o       = res_id_q;
  assign out_task_priority_o = res_prio_q;
  assign preempt_request_o   = res_pre_q;

endmodule

>>> hw/rtl/priority_run_queue_top.sv
// Channel   Direction  Payload
// s_axis    in         tuser: command; tdata: task_id, task_priority, was_runnable
// m_axis    out        tuser: status; tdata: out_task_id, out_task_priority, preempt_request
// cfg       in         cfg_data_i: preemption_enabled
//
// Each command is first captured into the held item and then run through
// the sorted shift-register queue, whose slots all compare and move in
// parallel. Execution waits while the result register still holds an
// untaken result; a new item is accepted while a result waits.
// Reset empties the queue, clears all marks, makes the idle task current and
// enables preemption; no clearing pass is needed.
module priority_run_queue_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [5:0] task_id, [13:6] task_priority, [14] was_runnable, [15] zero
  input  logic [prq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [1:0] command
  input  logic [prq_pkg::CMD_W-1:0]         s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [5:0] out_task_id, [13:6] out_task_priority, [14] preempt_request, [15] zero
  output logic [prq_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // [1:0] status
  output logic [prq_pkg::STATUS_W-1:0]      m_axis_tuser,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic                              cfg_data_i
);

  prq_pkg::ctrl_cmd_t               ctrl_cmd;
  logic [prq_pkg::TASK_ID_W-1:0]    res_id;
  logic [prq_pkg::PRIO_W-1:0]       res_prio;
  logic                             res_pre;
  logic                             s_xfer;

  assign cfg_ready_o = 1'b1;
  assign s_xfer      = s_axis_tvalid && s_axis_tready;

  prq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (ctrl_cmd)
  );

  prq_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (ctrl_cmd),
    .in_command_i        (s_axis_tuser),
    .in_task_id_i        (s_axis_tdata[5:0]),
    .in_task_priority_i  (s_axis_tdata[13:6]),
    .in_was_runnable_i   (s_axis_tdata[14]),
    .cfg_we_i            (cfg_valid_i),
    .cfg_data_i          (cfg_data_i),
    .status_o            (m_axis_tuser),
    .out_task_id_o       (res_id),
    .out_task_priority_o (res_prio),
    .preempt_request_o   (res_pre)
  );

  assign m_axis_tdata = {1'b0, res_pre, res_prio, res_id};

  // A preemption request comes only with a completed enqueue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[14] |-> m_axis_tuser == prq_pkg::ST_DONE)
    else $error("preemption request on a result that is not done");

  // A result without a popped task carries zero id and priority.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == prq_pkg::ST_EMPTY ||
                      m_axis_tuser == prq_pkg::ST_FULL ||
                      m_axis_tuser == prq_pkg::ST_IGNORED)
    |-> m_axis_tdata[13:0] == '0)
    else $error("task fields set on a result without a popped task");

  // An accepted item is executed before the next one is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> !s_axis_tready)
    else $error("input accepted again before execution");

  // A result appears only in the cycle after execution, never directly after capture.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result produced without an execute cycle");

endmodule
